[sv/ssaf_pkg.sv]
// ----------------------------------------------------------------------------
// ssaf_pkg: shared types and constants for the signal strength alert flasher
// Item layouts, register indexes, reset values and sizing defaults.
// ----------------------------------------------------------------------------
package ssaf_pkg;

  // Default sizing for the top-level parameters
  localparam int TIME_BITS_DEF   = 32;
  localparam int PERIOD_BITS_DEF = 16;

  // Interpolation divider: |offset| (8 bits) times |slow - fast| (16 bits)
  localparam int DIV_NUM_W = 24;
  localparam int DIV_DEN_W = 8;

  // Configuration port sizing
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEAK_LEVEL      = 3'd0,
    REG_STRONG_LEVEL    = 3'd1,
    REG_SLOW_PERIOD     = 3'd2,
    REG_FAST_PERIOD     = 3'd3,
    REG_BUZZ_CAP        = 3'd4,
    REG_BUZZ_ENABLE     = 3'd5,
    REG_BUZZ_ACTIVE_LOW = 3'd6,
    REG_HOLD_TIME       = 3'd7
  } cfg_reg_t;

  // Register reset values
  localparam logic signed [7:0] WEAK_LEVEL_RST   = -8'sd90;
  localparam logic signed [7:0] STRONG_LEVEL_RST = -8'sd40;
  localparam logic [15:0]       SLOW_PERIOD_RST  = 16'd1000;
  localparam logic [15:0]       FAST_PERIOD_RST  = 16'd100;
  localparam logic [15:0]       BUZZ_CAP_RST     = 16'd50;
  localparam logic              BUZZ_ENABLE_RST  = 1'b1;
  localparam logic              BUZZ_ALOW_RST    = 1'b0;
  localparam logic [31:0]       HOLD_TIME_RST    = 32'd3000;

  // Input item modes
  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_MUTE   = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [31:0]       now_ms;
    logic [31:0]       last_hit_ms;
    logic signed [7:0] best_rssi;
  } in_item_t;

  typedef struct packed {
    logic        led_level;
    logic        buzzer_level;
    logic        alert_on;
    logic [15:0] flash_period;
    logic        phase_on;
  } out_item_t;

endpackage

[sv/ssaf_div.sv]
// ----------------------------------------------------------------------------
// ssaf_div: unsigned restoring divider, one quotient bit per cycle
// Latches operands on start and pulses done with the quotient once all NUM_W bits are in.
// ----------------------------------------------------------------------------
module ssaf_div
  import ssaf_pkg::*;
#(
  parameter int NUM_W = DIV_NUM_W,
  parameter int DEN_W = DIV_DEN_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [NUM_W-1:0] work;     // dividend bits shift out, quotient bits shift in
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] divisor;

  logic [DEN_W:0]   rem_sh;
  logic             fits;
  logic [DEN_W:0]   rem_sub;

  always_comb begin
    rem_sh  = {rem, work[NUM_W-1]};
    fits    = rem_sh >= {1'b0, divisor};
    rem_sub = rem_sh - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        count   <= '0;
        work    <= num;
        rem     <= '0;
        divisor <= den;
      end else if (busy) begin
        work <= {work[NUM_W-2:0], fits};
        rem  <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        if (count == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count + 1'b1;
        end
      end
    end
  end

  assign quot = work;

endmodule

[sv/signal_strength_alert_flasher_top.sv]
// ----------------------------------------------------------------------------
// signal_strength_alert_flasher_top: alert LED flasher and buzzer driver
// Holds an alert after a detection hit and flashes at a rate set by signal
// strength, with a capped buzzer burst at the start of each on phase.
// ----------------------------------------------------------------------------
// Sequence: an accepted item passes S_EVAL and S_DONE for a mute item or an
//   update without a live hit; with the signal strength at or outside the
//   weak/strong levels it passes S_EVAL, S_PHASE and S_DONE, and an
//   interpolated period adds S_DIV (wait for the serial divider) and S_APPLY.
// Items: one at a time, no new item before the last is done; in_stall stays high from accept
//   until the result is loaded into the output register.
// Reset: synchronous; registers return to defaults, alert clear, pins off.
// ----------------------------------------------------------------------------
module signal_strength_alert_flasher_top
  import ssaf_pkg::*;
#(
  parameter int TIME_BITS   = TIME_BITS_DEF,
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // update / mute items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item
);

  // Compare widths: hold time is 32 bits, half period is PERIOD_BITS
  localparam int HW = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int CW = (TIME_BITS > PERIOD_BITS) ? TIME_BITS : PERIOD_BITS;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [7:0] weak_level;
  logic signed [7:0] strong_level;
  logic [15:0]       slow_period;
  logic [15:0]       fast_period;
  logic [15:0]       buzz_cap;
  logic              buzz_enable;
  logic              buzz_active_low;
  logic [31:0]       hold_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      weak_level      <= WEAK_LEVEL_RST;
      strong_level    <= STRONG_LEVEL_RST;
      slow_period     <= SLOW_PERIOD_RST;
      fast_period     <= FAST_PERIOD_RST;
      buzz_cap        <= BUZZ_CAP_RST;
      buzz_enable     <= BUZZ_ENABLE_RST;
      buzz_active_low <= BUZZ_ALOW_RST;
      hold_time       <= HOLD_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WEAK_LEVEL:      weak_level      <= cfg_data[7:0];
        REG_STRONG_LEVEL:    strong_level    <= cfg_data[7:0];
        REG_SLOW_PERIOD:     slow_period     <= cfg_data[15:0];
        REG_FAST_PERIOD:     fast_period     <= cfg_data[15:0];
        REG_BUZZ_CAP:        buzz_cap        <= cfg_data[15:0];
        REG_BUZZ_ENABLE:     buzz_enable     <= cfg_data[0];
        REG_BUZZ_ACTIVE_LOW: buzz_active_low <= cfg_data[0];
        REG_HOLD_TIME:       hold_time       <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state and flasher state
  // --------------------------------------------------------------------------
  typedef enum logic [2:0] {
    S_IDLE,   // wait for an item
    S_EVAL,   // decide alert, pick period or launch the divider
    S_DIV,    // wait for the interpolation quotient
    S_APPLY,  // fold quotient into the period
    S_PHASE,  // advance the flash phase and drive the pins
    S_DONE    // hand the result to the output register
  } state_t;

  state_t                 state;
  in_item_t               item;         // item under work
  logic                   alerting;
  logic [TIME_BITS-1:0]   phase_start;
  logic                   output_phase;
  logic                   mute_flag;
  logic [PERIOD_BITS-1:0] period_reg;
  logic                   led_pin;
  logic                   buzzer_pin;
  logic                   range_neg;    // slow period below fast period

  // --------------------------------------------------------------------------
  // Serial divider for the interpolation term
  // --------------------------------------------------------------------------
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quot;

  ssaf_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // --------------------------------------------------------------------------
  // Evaluation logic
  // --------------------------------------------------------------------------
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] last_t;
  logic [TIME_BITS-1:0] age;
  logic                 hit_active;
  logic                 rssi_low;
  logic                 rssi_high;
  logic signed [8:0]    span_full;
  logic signed [8:0]    offset_full;
  logic signed [16:0]   range_full;
  logic [15:0]          range_mag;
  logic [17:0]          interp_sum;

  // phase stage
  logic [PERIOD_BITS-1:0] half;
  logic [TIME_BITS-1:0]   elapsed;
  logic                   toggle;
  logic [TIME_BITS-1:0]   elapsed_eff;
  logic                   phase_new;
  logic                   buzz;

  always_comb begin
    now_t      = TIME_BITS'(item.now_ms);
    last_t     = TIME_BITS'(item.last_hit_ms);
    age        = now_t - last_t;
    hit_active = (last_t != '0) && (HW'(age) <= HW'(hold_time));

    rssi_low  = item.best_rssi <= weak_level;
    rssi_high = item.best_rssi >= strong_level;

    // Interpolation operands; the span and offset are positive whenever used
    span_full   = 9'(strong_level) - 9'(weak_level);
    offset_full = 9'(item.best_rssi) - 9'(weak_level);
    range_full  = $signed({1'b0, slow_period}) - $signed({1'b0, fast_period});
    range_mag   = range_full[16] ? 16'(-range_full) : range_full[15:0];

    div_start = (state == S_EVAL) && (item.mode == MODE_UPDATE) && hit_active &&
                !rssi_low && !rssi_high;
    div_num   = DIV_NUM_W'(offset_full[7:0]) * DIV_NUM_W'(range_mag);
    div_den   = span_full[7:0];

    // slow - trunc(offset * range / span); the quotient is a magnitude, range_neg picks the sign
    interp_sum = range_neg ? ({2'b00, slow_period} + 18'(div_quot))
                           : ({2'b00, slow_period} - 18'(div_quot));

    // Phase advance
    half        = period_reg >> 1;
    elapsed     = now_t - phase_start;
    toggle      = CW'(elapsed) >= CW'(half);
    elapsed_eff = toggle ? '0 : elapsed;
    phase_new   = toggle ? !output_phase : output_phase;
    buzz        = phase_new && !mute_flag && (elapsed_eff < TIME_BITS'(buzz_cap));
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      alerting     <= 1'b0;
      phase_start  <= '0;
      output_phase <= 1'b0;
      mute_flag    <= 1'b0;
      period_reg   <= PERIOD_BITS'(SLOW_PERIOD_RST);
      led_pin      <= 1'b0;
      buzzer_pin   <= BUZZ_ALOW_RST;
      range_neg    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one is loaded this cycle
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_item;
            state <= S_EVAL;
          end
        end

        S_EVAL: begin
          if (item.mode == MODE_MUTE) begin
            // Mute only sticks while the alert holds; pins wait for an update
            if (alerting) begin
              mute_flag <= 1'b1;
            end
            state <= S_DONE;
          end else if (!hit_active) begin
            // Leave the alert: phase and mute clear, both pins off
            if (alerting) begin
              alerting     <= 1'b0;
              output_phase <= 1'b0;
              mute_flag    <= 1'b0;
              led_pin      <= 1'b0;
              buzzer_pin   <= buzz_active_low;
            end
            state <= S_DONE;
          end else begin
            if (!alerting) begin
              // Enter the alert with a fresh on phase
              alerting     <= 1'b1;
              phase_start  <= now_t;
              output_phase <= 1'b1;
            end
            range_neg <= range_full[16];
            if (rssi_low) begin
              period_reg <= PERIOD_BITS'(slow_period);
              state      <= S_PHASE;
            end else if (rssi_high) begin
              period_reg <= PERIOD_BITS'(fast_period);
              state      <= S_PHASE;
            end else begin
              state <= S_DIV;
            end
          end
        end

        S_DIV: begin
          if (div_done) begin
            state <= S_APPLY;
          end
        end

        S_APPLY: begin
          period_reg <= PERIOD_BITS'(interp_sum[15:0]);
          state      <= S_PHASE;
        end

        S_PHASE: begin
          output_phase <= phase_new;
          if (toggle) begin
            phase_start <= now_t;
          end
          led_pin    <= phase_new;
          buzzer_pin <= (buzz_enable && buzz) ^ buzz_active_low;
          state      <= S_DONE;
        end

        S_DONE: begin
          // Hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid             <= 1'b1;
            out_item.led_level    <= led_pin;
            out_item.buzzer_level <= buzzer_pin;
            out_item.alert_on     <= alerting;
            out_item.flash_period <= 16'(period_reg);
            out_item.phase_on     <= output_phase;
            state                 <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule
